// ----- rtl/core/pidt_pkg.sv -----
// Shared constants and types for the timestamped PID controller.
// Holds fixed-point widths and the request/response structs of the shared units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pidt_pkg;

  // Fixed-point format of every data field: signed Q16.16
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // Full product and product after dropping the fraction bits
  localparam int PROD_W = 2 * DATA_W;
  localparam int MAG_W  = PROD_W - FRAC_W;

  // Working width of the P, I and D terms and their sums
  localparam int TERM_W = MAG_W + 2;

  // Derivative divider: quotient magnitude, divisor and dividend magnitude widths
  localparam int QUO_W = DATA_W;
  localparam int DEN_W = DATA_W + 1;
  localparam int NUM_W = DATA_W + 3;
  localparam int CNT_W = $clog2(QUO_W);

  // Ten in Q format, the smoothing weight of the derivative filter
  localparam logic [DEN_W-1:0] TEN_Q = DEN_W'(10) << FRAC_W;

  typedef logic [DATA_W-1:0] word_t;

  // Request to the shared multiplier: magnitudes and the sign of the product
  typedef struct packed {
    logic  go;
    logic  neg;
    word_t a;
    word_t b;
  } mul_req_t;

  // Request to the serial divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // Divider status and quotient magnitude
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/pid_controller_timestamped.sv -----
// Timestamped PID controller, signed Q16.16, top level with sequencer and state.
// An update with a nonzero time step runs the full sequence, including the serial
// divider; a set item or a zero time step goes straight to queuing the result.
// The next item is accepted in the cycle after the result is queued.
// Reset (rst_n low, synchronous) clears gains and integral limits to zero, command
// limits to the full signed range, and all controller state to zero.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_timestamped (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_opcode,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_error_in,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_time_stamp,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_forced_drive,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pidt_pkg::DATA_W-1:0]      out_drive_out,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [pidt_pkg::DATA_W-1:0] cfg_data
);

  // Register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [2:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [2:0] REG_DRIVE_UPPER = 3'd5;
  localparam logic [2:0] REG_DRIVE_LOWER = 3'd6;

  // Opcodes
  localparam logic OP_UPDATE = 1'b0;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P    = 4'd1;   // issue kp*e
  localparam logic [3:0] S_I    = 4'd2;   // take P, issue dt*e
  localparam logic [3:0] S_IS   = 4'd3;   // integral sum, issue deriv*10
  localparam logic [3:0] S_IC   = 4'd4;   // clamp integral, form numerator
  localparam logic [3:0] S_DS   = 4'd5;   // start divider, issue ki*I
  localparam logic [3:0] S_IT   = 4'd6;   // P + I term
  localparam logic [3:0] S_DW   = 4'd7;   // wait for quotient
  localparam logic [3:0] S_DM   = 4'd8;   // issue kd*D
  localparam logic [3:0] S_DA   = 4'd9;   // add D term
  localparam logic [3:0] S_CL   = 4'd10;  // clamp command
  localparam logic [3:0] S_DONE = 4'd11;  // queue result

  localparam int SX_W = pidt_pkg::TERM_W - pidt_pkg::DATA_W;
  localparam logic [pidt_pkg::DATA_W-1:0] SMAX = {1'b0, {(pidt_pkg::DATA_W-1){1'b1}}};
  localparam logic [pidt_pkg::DATA_W-1:0] SMIN = {1'b1, {(pidt_pkg::DATA_W-1){1'b0}}};

  typedef logic signed [pidt_pkg::TERM_W-1:0] term_t;

  // Sign-extend a data word to the working width
  function automatic term_t sext(input pidt_pkg::word_t x);
    return $signed({{SX_W{x[pidt_pkg::DATA_W-1]}}, x});
  endfunction

  // Magnitude of a signed data word
  function automatic pidt_pkg::word_t abs_w(input pidt_pkg::word_t x);
    return x[pidt_pkg::DATA_W-1] ? pidt_pkg::word_t'(-x) : x;
  endfunction

  // Add or subtract a product magnitude
  function automatic term_t addsub(input term_t base, input logic [pidt_pkg::MAG_W-1:0] m,
                                   input logic neg);
    term_t mx;
    mx = $signed({{(pidt_pkg::TERM_W-pidt_pkg::MAG_W){1'b0}}, m});
    return neg ? base - mx : base + mx;
  endfunction

  // Clamp to upper then lower limit; the result always fits a data word
  function automatic pidt_pkg::word_t clamp(input term_t v, input pidt_pkg::word_t hi,
                                            input pidt_pkg::word_t lo);
    if (v > sext(hi)) return hi;
    else if (v < sext(lo)) return lo;
    else return v[pidt_pkg::DATA_W-1:0];
  endfunction

  // Configuration registers
  pidt_pkg::word_t prop_gain_r, integ_gain_r, deriv_gain_r;
  pidt_pkg::word_t integ_upper_r, integ_lower_r, drive_upper_r, drive_lower_r;

  // Controller state
  pidt_pkg::word_t prev_error_r, deriv_est_r, integ_acc_r, held_drive_r, prev_time_r;
  logic            time_seen_r;

  // Sequencer and output register
  logic [3:0]      state_r, state_nxt;
  logic            out_valid_r;
  pidt_pkg::word_t out_drive_r;

  // Working registers of one update
  pidt_pkg::word_t            e_r, dt_r;
  logic [pidt_pkg::DEN_W-1:0] den_r;
  term_t                      ediff_r, p_r, isum_r, num_r, pi_r, cmd_r;

  // Shared units
  pidt_pkg::mul_req_t          mul_req;
  logic [pidt_pkg::MAG_W-1:0]  mul_mag;
  logic                        mul_neg;
  pidt_pkg::div_req_t          div_req;
  pidt_pkg::div_rsp_t          div_rsp;

  logic            in_xfer;
  logic            out_load;
  pidt_pkg::word_t dt_w;
  pidt_pkg::word_t ig_w;
  pidt_pkg::word_t d_w;
  term_t           num_abs;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive_out = out_drive_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Time step: wrapping difference, zero before any stamp was seen
  assign dt_w = time_seen_r ? pidt_pkg::word_t'(in_time_stamp - prev_time_r) : '0;

  // Clamped integral from the registered sum
  assign ig_w = clamp(isum_r, integ_upper_r, integ_lower_r);

  // Saturate the quotient magnitude to a signed word with the numerator's sign
  always_comb begin
    if (num_r[pidt_pkg::TERM_W-1]) begin
      d_w = div_rsp.quo[pidt_pkg::QUO_W-1] ? SMIN : pidt_pkg::word_t'(-div_rsp.quo);
    end else begin
      d_w = div_rsp.quo[pidt_pkg::QUO_W-1] ? SMAX : div_rsp.quo;
    end
  end

  assign num_abs = num_r[pidt_pkg::TERM_W-1] ? -num_r : num_r;

  // Multiplier operand selection per step
  always_comb begin
    mul_req = '0;
    case (state_r)
      S_P: begin
        mul_req.go  = 1'b1;
        mul_req.a   = abs_w(prop_gain_r);
        mul_req.b   = abs_w(e_r);
        mul_req.neg = prop_gain_r[pidt_pkg::DATA_W-1] ^ e_r[pidt_pkg::DATA_W-1];
      end
      S_I: begin
        mul_req.go  = 1'b1;
        mul_req.a   = dt_r;
        mul_req.b   = abs_w(e_r);
        mul_req.neg = e_r[pidt_pkg::DATA_W-1];
      end
      S_IS: begin
        mul_req.go  = 1'b1;
        mul_req.a   = abs_w(deriv_est_r);
        mul_req.b   = pidt_pkg::DATA_W'(pidt_pkg::TEN_Q);
        mul_req.neg = deriv_est_r[pidt_pkg::DATA_W-1];
      end
      S_DS: begin
        mul_req.go  = 1'b1;
        mul_req.a   = abs_w(integ_gain_r);
        mul_req.b   = abs_w(integ_acc_r);
        mul_req.neg = integ_gain_r[pidt_pkg::DATA_W-1] ^ integ_acc_r[pidt_pkg::DATA_W-1];
      end
      S_DM: begin
        mul_req.go  = 1'b1;
        mul_req.a   = abs_w(deriv_gain_r);
        mul_req.b   = abs_w(deriv_est_r);
        mul_req.neg = deriv_gain_r[pidt_pkg::DATA_W-1] ^ deriv_est_r[pidt_pkg::DATA_W-1];
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Divider request: numerator magnitude fits NUM_W bits by range
  always_comb begin
    div_req.start   = (state_r == S_DS);
    div_req.num_mag = num_abs[pidt_pkg::NUM_W-1:0];
    div_req.den     = den_r;
  end

  pidt_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .mag (mul_mag),
    .neg (mul_neg)
  );

  pidt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_opcode != OP_UPDATE || dt_w == '0) state_nxt = S_DONE;
          else state_nxt = S_P;
        end
      end
      S_P:    state_nxt = S_I;
      S_I:    state_nxt = S_IS;
      S_IS:   state_nxt = S_IC;
      S_IC:   state_nxt = S_DS;
      S_DS:   state_nxt = S_IT;
      S_IT:   state_nxt = S_DW;
      S_DW: begin
        if (div_rsp.done) state_nxt = S_DM;
      end
      S_DM:   state_nxt = S_DA;
      S_DA:   state_nxt = S_CL;
      S_CL:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      integ_upper_r <= '0;
      integ_lower_r <= '0;
      drive_upper_r <= SMAX;
      drive_lower_r <= SMIN;
      prev_error_r  <= '0;
      deriv_est_r   <= '0;
      integ_acc_r   <= '0;
      held_drive_r  <= '0;
      prev_time_r   <= '0;
      time_seen_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Hold the result until the transfer completes
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      // Register writes; unknown indexes drop
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_gain_r   <= cfg_data;
          REG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
          REG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
          REG_INTEG_UPPER: integ_upper_r <= cfg_data;
          REG_INTEG_LOWER: integ_lower_r <= cfg_data;
          REG_DRIVE_UPPER: drive_upper_r <= cfg_data;
          REG_DRIVE_LOWER: drive_lower_r <= cfg_data;
          default: ;
        endcase
      end

      // Set item overwrites the command; update item advances the time stamp
      if (in_xfer) begin
        if (in_opcode != OP_UPDATE) begin
          held_drive_r <= in_forced_drive;
        end else begin
          time_seen_r <= 1'b1;
          prev_time_r <= in_time_stamp;
        end
      end

      if (state_r == S_IC) integ_acc_r <= ig_w;
      if (state_r == S_DW && div_rsp.done) deriv_est_r <= d_w;
      if (state_r == S_CL) begin
        held_drive_r <= clamp(cmd_r, drive_upper_r, drive_lower_r);
        prev_error_r <= e_r;
      end
    end
  end

  // Working registers of the update sequence
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      e_r     <= in_error_in;
      dt_r    <= dt_w;
      ediff_r <= sext(in_error_in) - sext(prev_error_r);
    end
    case (state_r)
      S_P:  den_r  <= {1'b0, dt_r} + pidt_pkg::TEN_Q;
      S_I:  p_r    <= addsub('0, mul_mag, mul_neg);
      S_IS: isum_r <= addsub(sext(integ_acc_r), mul_mag, mul_neg);
      S_IC: num_r  <= addsub(ediff_r, mul_mag, mul_neg);
      S_IT: pi_r   <= addsub(p_r, mul_mag, mul_neg);
      S_DA: cmd_r  <= addsub(pi_r, mul_mag, mul_neg);
      default: ;
    endcase
    if (out_load) out_drive_r <= held_drive_r;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pidt_mul.sv -----
// Shared multiplier of the timestamped PID controller.
// Unsigned magnitude product with registered result and sign; uses pidt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidt_mul (
  input  wire logic                      clk,
  input  wire pidt_pkg::mul_req_t        req,
  output logic [pidt_pkg::MAG_W-1:0]     mag,
  output logic                           neg
);

  logic [pidt_pkg::PROD_W-1:0] prod_r;
  logic                        neg_r;

  // Capture the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= {{pidt_pkg::DATA_W{1'b0}}, req.a} * {{pidt_pkg::DATA_W{1'b0}}, req.b};
      neg_r  <= req.neg;
    end
  end

  // Drop the fraction bits: truncation of the magnitude rounds toward zero
  assign mag = prod_r[pidt_pkg::PROD_W-1:pidt_pkg::FRAC_W];
  assign neg = neg_r;

endmodule

`default_nettype wire

// ----- rtl/core/pidt_div.sv -----
// Serial restoring divider for the derivative filter of the PID controller.
// One quotient bit per cycle, QUO_W bits in all; uses pidt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pidt_pkg::div_req_t req,
  output pidt_pkg::div_rsp_t      rsp
);

  logic [pidt_pkg::DEN_W-1:0] rem_r;
  logic [pidt_pkg::DEN_W-1:0] den_r;
  logic [pidt_pkg::QUO_W-1:0] quo_r;
  logic [pidt_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [pidt_pkg::DEN_W:0]   trial;
  logic [pidt_pkg::DEN_W:0]   diff;
  logic                       ge;
  logic [pidt_pkg::DEN_W-1:0] rem_nxt;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    trial   = {rem_r, quo_r[pidt_pkg::QUO_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[pidt_pkg::DEN_W-1:0] : trial[pidt_pkg::DEN_W-1:0];
  end

  // Control: run for QUO_W steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == pidt_pkg::CNT_W'(pidt_pkg::QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: the high dividend bits start as the remainder, which stays below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= pidt_pkg::DEN_W'(req.num_mag[pidt_pkg::NUM_W-1:pidt_pkg::FRAC_W]);
      quo_r <= {req.num_mag[pidt_pkg::FRAC_W-1:0], {pidt_pkg::FRAC_W{1'b0}}};
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[pidt_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ----- tb/sv/pidt_tb_pkg.sv -----
`timescale 1ns / 1ps
// Opcode and register index codes shared by the PID controller testbench files.
// No dependencies.

package pidt_tb_pkg;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_SET    = 1'b1
  } op_e;

  // Index 7 has no register behind it; writes to it are dropped
  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_UPPER = 3'd3,
    REG_INTEG_LOWER = 3'd4,
    REG_DRIVE_UPPER = 3'd5,
    REG_DRIVE_LOWER = 3'd6,
    REG_SPARE       = 3'd7
  } reg_e;

endpackage

// ----- tb/sv/pidt_checker.sv -----
`timescale 1ns / 1ps
// Drive-value checker for the timestamped PID controller: snoops all three channels,
// predicts each held command and compares it with the returned one.
// Depends on pidt_pkg and pidt_tb_pkg.

module pidt_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        in_opcode,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_error_in,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_time_stamp,
  input  wire logic [pidt_pkg::DATA_W-1:0] in_forced_drive,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [pidt_pkg::DATA_W-1:0] out_drive_out,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [pidt_pkg::DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               awaiting
);

  import pidt_pkg::*;
  import pidt_tb_pkg::*;

  localparam longint I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'h8000_0000_0000_0000;
  localparam longint W_MAX   = 64'sd2147483647;
  localparam longint W_MIN   = -64'sd2147483648;
  localparam longint TEN_Q64 = 64'd10 << FRAC_W;

  // Register copies
  word_t prop_k, integ_k, deriv_k, integ_hi, integ_lo, drive_hi, drive_lo;

  // Controller state copies
  word_t last_err, deriv_est, integ_sum, held, last_stamp;
  logic  stamp_seen;

  word_t drive_due[$];
  word_t want;

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  function automatic longint sx(word_t w);
    longint v;
    v = signed'(w);
    return v;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Apply a sign to a magnitude, saturating to 64 bits
  function automatic longint clip64(logic [63:0] m, bit neg);
    if (neg)
      return m[63] ? I64_MIN : -longint'(m);
    return m[63] ? I64_MAX : longint'(m);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (s > I64_MAX)
      return I64_MAX;
    if (s < I64_MIN)
      return I64_MIN;
    return s[63:0];
  endfunction

  function automatic longint to_word(longint v);
    if (v > W_MAX)
      return W_MAX;
    if (v < W_MIN)
      return W_MIN;
    return v;
  endfunction

  // Exact product of magnitudes, drop the fraction bits toward zero
  function automatic longint qmul(logic [63:0] a, logic [63:0] b, bit neg);
    logic [127:0] prod;
    prod = a;
    prod = (prod * b) >> FRAC_W;
    if (prod[127:64] != '0)
      return neg ? I64_MIN : I64_MAX;
    return clip64(prod[63:0], neg);
  endfunction

  function automatic longint mul_signed(longint a, longint b);
    return qmul(abs64(a), abs64(b), (a < 0) != (b < 0));
  endfunction

  // Fixed-point quotient of magnitudes, truncated toward zero
  function automatic longint qdiv(logic [63:0] n, logic [63:0] d, bit neg);
    logic [127:0] quo;
    logic [127:0] wide_d;
    quo    = n;
    wide_d = d;
    quo    = (quo << FRAC_W) / wide_d;
    if (quo[127:64] != '0)
      return neg ? I64_MIN : I64_MAX;
    return clip64(quo[63:0], neg);
  endfunction

  // Advance the controller copy by one item and return the held command
  function automatic word_t next_drive(logic op, word_t err, word_t ts, word_t forced);
    word_t       dt;
    longint      e, p, ig, num, d, cmd;
    logic [63:0] den;
    if (op == OP_SET) begin
      held = forced;
      return held;
    end
    if (!stamp_seen) begin
      stamp_seen = 1'b1;
      last_stamp = ts;
    end
    dt = ts - last_stamp;
    if (dt != '0) begin
      e = sx(err);
      p = mul_signed(sx(prop_k), e);

      // Integrate, upper clamp first so inverted limits favor the upper one
      ig = add_sat(sx(integ_sum), qmul(64'(dt), abs64(e), e < 0));
      if (ig > sx(integ_hi))
        ig = sx(integ_hi);
      else if (ig < sx(integ_lo))
        ig = sx(integ_lo);
      ig = to_word(ig);
      integ_sum = word_t'(ig);

      // Smoothed derivative
      num = add_sat(mul_signed(sx(deriv_est), TEN_Q64), add_sat(e, -sx(last_err)));
      den = 64'(dt) + 64'(TEN_Q64);
      d   = to_word(qdiv(abs64(num), den, num < 0));
      deriv_est = word_t'(d);
      last_err  = err;

      cmd = add_sat(add_sat(p, mul_signed(sx(integ_k), ig)), mul_signed(sx(deriv_k), d));
      if (cmd > sx(drive_hi))
        cmd = sx(drive_hi);
      else if (cmd < sx(drive_lo))
        cmd = sx(drive_lo);
      held = word_t'(to_word(cmd));
    end
    last_stamp = ts;
    return held;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prop_k     = '0;
      integ_k    = '0;
      deriv_k    = '0;
      integ_hi   = '0;
      integ_lo   = '0;
      drive_hi   = 32'h7FFF_FFFF;
      drive_lo   = 32'h8000_0000;
      last_err   = '0;
      deriv_est  = '0;
      integ_sum  = '0;
      held       = '0;
      last_stamp = '0;
      stamp_seen = 1'b0;
      drive_due.delete();
    end else begin
      // Compare a result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (drive_due.size() == 0) begin
          $display("%0t: drive_out %h arrived, expected none", $time, out_drive_out);
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          if (out_drive_out !== want) begin
            $display("%0t: drive_out mismatch, expected %h, actual %h",
                     $time, want, out_drive_out);
            mismatches++;
          end
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_k   = cfg_data;
          REG_INTEG_GAIN:  integ_k  = cfg_data;
          REG_DERIV_GAIN:  deriv_k  = cfg_data;
          REG_INTEG_UPPER: integ_hi = cfg_data;
          REG_INTEG_LOWER: integ_lo = cfg_data;
          REG_DRIVE_UPPER: drive_hi = cfg_data;
          REG_DRIVE_LOWER: drive_lo = cfg_data;
          default: ;
        endcase
      end

      // Predict for every input transfer
      if (in_valid && !in_stall)
        drive_due.push_back(next_drive(in_opcode, in_error_in, in_time_stamp,
                                       in_forced_drive));
    end
    awaiting = drive_due.size();
  end

endmodule

// ----- tb/sv/pid_controller_timestamped_tb.sv -----
`timescale 1ns / 1ps
// Top of the timestamped PID controller testbench: clock, reset, stimulus and verdict.
// Depends on pidt_pkg, pidt_tb_pkg, pidt_checker and the controller RTL.

module pid_controller_timestamped_tb;

  import pidt_pkg::*;
  import pidt_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 50;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 75;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_opcode       = 1'b0;
  word_t       in_error_in     = '0;
  word_t       in_time_stamp   = '0;
  word_t       in_forced_drive = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  word_t       out_drive_out;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index       = '0;
  word_t       cfg_data        = '0;

  int    mismatches;
  int    awaiting;
  int    cycles = 0;
  bit    calm   = 1'b0;   // no idling on either side while set
  word_t stamp  = '0;

  always #5 clk = ~clk;

  pid_controller_timestamped u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_error_in     (in_error_in),
    .in_time_stamp   (in_time_stamp),
    .in_forced_drive (in_forced_drive),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_out   (out_drive_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  pidt_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_error_in     (in_error_in),
    .in_time_stamp   (in_time_stamp),
    .in_forced_drive (in_forced_drive),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_out   (out_drive_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: hold stall for a random number of valid cycles, then take the transfer
  initial begin : result_side
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      out_stall <= (gap != 0);
      while (gap > 0) begin
        @(negedge clk);
        if (out_valid)
          gap--;
        if (gap == 0)
          out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Idle for a random gap, then present one item until its transfer
  task automatic send(op_e op, word_t err, word_t ts, word_t fd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_error_in     <= err;
    in_time_stamp   <= ts;
    in_forced_drive <= fd;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic update(word_t err, word_t step);
    stamp = stamp + step;
    send(OP_UPDATE, err, stamp, $urandom());
  endtask

  task automatic force_drive(word_t fd);
    send(OP_SET, $urandom(), $urandom(), fd);
  endtask

  // Drop valid, wait for every predicted result, then let the block settle
  task automatic drain(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(reg_e idx, word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(word_t kp, word_t ki, word_t kd, word_t iu, word_t il,
                           word_t cu, word_t cl);
    drain(4);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_INTEG_UPPER, iu);
    write_reg(REG_INTEG_LOWER, il);
    write_reg(REG_DRIVE_UPPER, cu);
    write_reg(REG_DRIVE_LOWER, cl);
  endtask

  function automatic word_t signed_small(int unsigned span);
    word_t m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic word_t pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return $urandom();
      default: return signed_small(32'h0004_0000);
    endcase
  endfunction

  function automatic word_t pick_bound();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom();
      default: return signed_small(32'h0100_0000);
    endcase
  endfunction

  function automatic word_t pick_error();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return signed_small(32'h0005_0000);
      default: return $urandom();
    endcase
  endfunction

  // Random gains and limits; ordered limits unless inversion is wanted
  task automatic random_regs(bit ordered);
    word_t iu, il, cu, cl, tmp;
    iu = pick_bound();
    il = pick_bound();
    cu = pick_bound();
    cl = pick_bound();
    if (ordered && signed'(iu) < signed'(il)) begin
      tmp = iu;
      iu  = il;
      il  = tmp;
    end
    if (ordered && signed'(cu) < signed'(cl)) begin
      tmp = cu;
      cu  = cl;
      cl  = tmp;
    end
    load_regs(pick_gain(), pick_gain(), pick_gain(), iu, il, cu, cl);
  endtask

  initial begin : stimulus
    word_t step;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: first item has no time step, zero gains hold zero
    stamp = 32'h0001_0000;
    update(32'h0000_0005, '0);
    update(32'h7FFF_FFFF, '0);
    update(32'h7FFF_FFFF, 32'h0001_0000);
    force_drive(32'h8000_0000);
    update(32'hFFFF_FFFF, '0);
    force_drive(32'h7FFF_FFFF);

    // Moderate gains and limits; spare index must be ignored
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0064_0000,
              32'hFF9C_0000, 32'h0032_0000, 32'hFFCE_0000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    update(32'h0002_0000, 32'h0000_8000);
    update(32'h7FFF_FFFF, 32'h0001_0000);
    update(32'h8000_0000, 32'h0001_0000);
    update(32'h0000_0000, 32'h0001_0000);
    update(32'hFFFF_FFFF, 32'h0000_0001);
    update(32'h0001_0000, 32'hFFFF_FFFF);
    force_drive(32'h0000_1234);
    update(32'h0000_8000, '0);
    update(32'h0000_0100, 32'hFFFF_0000);

    // Inverted integral and command limits
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'hFFF6_0000,
              32'h000A_0000, 32'hFFFF_0000, 32'h0001_0000);
    update(32'h0003_0000, 32'h0000_4000);
    update(32'hFFFD_0000, 32'h0000_4000);
    update(32'h0000_0000, 32'h0002_0000);
    update(32'h7FFF_FFFF, 32'h0000_0010);

    // Extreme gains, full-range limits
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    update(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    update(32'h8000_0000, 32'h0000_0001);
    update(32'h8000_0000, 32'h7FFF_FFFF);
    update(32'h7FFF_FFFF, 32'h0001_0000);

    // Random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      random_regs(ph != 4);
      calm = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2)
          drain(0);
        if ($urandom_range(0, 9) == 0) begin
          force_drive(pick_error());
        end else begin
          case ($urandom_range(0, 9))
            0:       step = '0;
            1:       step = $urandom();
            default: step = $urandom_range(1, 32'h0002_0000);
          endcase
          update(pick_error(), step);
        end
      end
    end
    calm = 1'b0;

    drain(DRAIN_CYCLES);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pidt_pkg.sv
rtl/core/pidt_mul.sv
rtl/core/pidt_div.sv
rtl/core/pid_controller_timestamped.sv
tb/sv/pidt_tb_pkg.sv
tb/sv/pidt_checker.sv
tb/sv/pid_controller_timestamped_tb.sv
